@@ design/dvt_pkg.sv @@
// Shared types and fixed field widths of the distance vector table update unit.
package dvt_pkg;

  localparam int COST_W = 10;
  localparam int ID_W   = 2;
  localparam int MASK_W = 4;
  localparam int OP_W   = 2;
  localparam int CFG_W  = 2;
  localparam int VEC_N  = 4;

  localparam logic [CFG_W-1:0] CFG_SELF_ID       = 2'd0;
  localparam logic [CFG_W-1:0] CFG_NEIGHBOR_MASK = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_RECV  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_WRITE,
    ST_LINK,
    ST_RELAX_A,
    ST_RELAX_B,
    ST_SYM_A,
    ST_SYM_B,
    ST_SYM_DIAG,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_DONE
  } state_t;

endpackage

@@ design/distance_vector_table_update_unit.sv @@
// Distance vector cost table with clear, entry write and neighbor vector relaxation.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in_     | in        | in_valid / in_ready  | opcode, sender_id, entry_row/col/value,
//          |           |                      | min_cost_0..3
//  out_    | out       | out_valid/out_ready  | updated, own_cost_0..3
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_wdata (self_id, neighbor_mask)
//
// The table memory has a single write port: each relaxed destination first stores the sender's
// column and, if the sum is lower, writes the own entry; the symmetric pass works column by column.
// After reset the table memory is swept to INF_COST, one entry a cycle over all DEPTH entries
// (DEPTH = 4**clog2(NODES)); in_ready stays low meanwhile, configuration writes are taken.
// One request is worked at a time; a finished result waits in the output register while the
// next request is accepted, and the block stalls before its next result until that one is taken.
module distance_vector_table_update_unit #(
  parameter int NODES    = 4,
  parameter int INF_COST = 999
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dvt_pkg::OP_W-1:0]     in_opcode,
  input  logic [dvt_pkg::ID_W-1:0]     in_sender_id,
  input  logic [dvt_pkg::ID_W-1:0]     in_entry_row,
  input  logic [dvt_pkg::ID_W-1:0]     in_entry_col,
  input  logic [dvt_pkg::COST_W-1:0]   in_entry_value,
  input  logic [dvt_pkg::COST_W-1:0]   in_min_cost_0,
  input  logic [dvt_pkg::COST_W-1:0]   in_min_cost_1,
  input  logic [dvt_pkg::COST_W-1:0]   in_min_cost_2,
  input  logic [dvt_pkg::COST_W-1:0]   in_min_cost_3,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_updated,
  output logic [dvt_pkg::COST_W-1:0]   out_own_cost_0,
  output logic [dvt_pkg::COST_W-1:0]   out_own_cost_1,
  output logic [dvt_pkg::COST_W-1:0]   out_own_cost_2,
  output logic [dvt_pkg::COST_W-1:0]   out_own_cost_3,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dvt_pkg::CFG_W-1:0]    cfg_index,
  input  logic [dvt_pkg::MASK_W-1:0]   cfg_wdata
);

  localparam int IDXW  = $clog2(NODES);
  localparam int XW    = (IDXW > dvt_pkg::ID_W) ? IDXW : dvt_pkg::ID_W;
  localparam int AW    = 2 * IDXW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = dvt_pkg::COST_W;

  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NODES - 1);
  localparam logic [AW-1:0]   LAST_ADR = AW'(DEPTH - 1);
  localparam logic [CW-1:0]   INF      = CW'(INF_COST);

  dvt_pkg::state_t state_r, state_nxt;

  logic [dvt_pkg::ID_W-1:0]   self_id_r;
  logic [dvt_pkg::MASK_W-1:0] nbr_mask_r;

  logic [dvt_pkg::ID_W-1:0]   sender_r;
  logic [dvt_pkg::ID_W-1:0]   row_r;
  logic [dvt_pkg::ID_W-1:0]   col_r;
  logic [CW-1:0]              value_r;
  logic [CW-1:0]              min_r [dvt_pkg::VEC_N];

  logic [IDXW-1:0]            idx_i_r;
  logic [IDXW-1:0]            idx_j_r;
  logic [AW-1:0]              clr_cnt_r;
  logic                       diag_r;
  logic [CW-1:0]              link_r;
  logic                       upd_r;
  logic [CW-1:0]              own_r [dvt_pkg::VEC_N];

  logic                       out_valid_r;
  logic                       out_updated_r;
  logic [CW-1:0]              out_cost_r [dvt_pkg::VEC_N];

  // table memory, [destination][via] packed as {row, col}
  logic [CW-1:0]              mem [DEPTH];
  logic [CW-1:0]              rd0_r;
  logic [CW-1:0]              rd1_r;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [CW-1:0]              mem_wd;
  logic [AW-1:0]              mem_ra0;
  logic [AW-1:0]              mem_ra1;

  logic                       in_acc;
  logic                       out_free;
  logic [IDXW-1:0]            self_idx;
  logic [IDXW-1:0]            sender_idx;
  logic                       self_ok;
  logic                       relax_en;
  logic [CW-1:0]              vec_i;
  logic [CW:0]                relax_sum;
  logic                       relax_better;
  logic                       sym_swap;
  logic [IDXW-1:0]            idx_j_inc;

  function automatic logic [IDXW-1:0] to_idx(input logic [dvt_pkg::ID_W-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return w[IDXW-1:0];
  endfunction

  function automatic logic lt_nodes(input logic [dvt_pkg::ID_W-1:0] v);
    return 32'(v) < NODES;
  endfunction

  // nodes beyond the mask width are never neighbors
  function automatic logic is_nbr(input logic [IDXW-1:0] i,
                                  input logic [dvt_pkg::MASK_W-1:0] mask);
    logic [XW-1:0] w;
    w = XW'(i);
    return ((w >> 2) == '0) ? mask[w[1:0]] : 1'b0;
  endfunction

  assign in_acc     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign self_idx   = to_idx(self_id_r);
  assign sender_idx = to_idx(sender_r);
  assign self_ok    = lt_nodes(self_id_r);
  // with self as sender the own column just takes the vector, nothing can drop below it
  assign relax_en   = self_ok && (self_id_r != sender_r);
  assign idx_j_inc  = idx_j_r + 1'b1;

  always_comb begin
    logic [XW-1:0] w;
    w = XW'(idx_i_r);
    vec_i = ((w >> 2) == '0) ? min_r[w[1:0]] : INF;
  end

  assign relax_sum    = {1'b0, vec_i} + {1'b0, link_r};
  assign relax_better = relax_en && ({1'b0, rd0_r} > relax_sum);
  assign sym_swap     = !is_nbr(idx_i_r, nbr_mask_r) && (rd0_r > rd1_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dvt_pkg::ST_INIT: begin
        if (clr_cnt_r == LAST_ADR) state_nxt = dvt_pkg::ST_IDLE;
      end
      dvt_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (dvt_pkg::opcode_t'(in_opcode))
            dvt_pkg::OP_CLEAR: state_nxt = dvt_pkg::ST_FILL;
            dvt_pkg::OP_WRITE: state_nxt = dvt_pkg::ST_WRITE;
            dvt_pkg::OP_RECV:  state_nxt = lt_nodes(in_sender_id) ? dvt_pkg::ST_LINK
                                                                   : dvt_pkg::ST_RD0;
            dvt_pkg::OP_NOP:   state_nxt = dvt_pkg::ST_RD0;
          endcase
        end
      end
      dvt_pkg::ST_FILL: begin
        if (clr_cnt_r == LAST_ADR) state_nxt = dvt_pkg::ST_RD0;
      end
      dvt_pkg::ST_WRITE:   state_nxt = dvt_pkg::ST_RD0;
      dvt_pkg::ST_LINK:    state_nxt = dvt_pkg::ST_RELAX_A;
      dvt_pkg::ST_RELAX_A: state_nxt = dvt_pkg::ST_RELAX_B;
      dvt_pkg::ST_RELAX_B: begin
        state_nxt = (idx_i_r == LAST_IDX) ? dvt_pkg::ST_SYM_A : dvt_pkg::ST_RELAX_A;
      end
      dvt_pkg::ST_SYM_A:   state_nxt = dvt_pkg::ST_SYM_B;
      dvt_pkg::ST_SYM_B: begin
        if (idx_j_r == LAST_IDX) state_nxt = dvt_pkg::ST_SYM_DIAG;
      end
      dvt_pkg::ST_SYM_DIAG: begin
        state_nxt = (idx_i_r == LAST_IDX) ? dvt_pkg::ST_RD0 : dvt_pkg::ST_SYM_A;
      end
      dvt_pkg::ST_RD0: state_nxt = dvt_pkg::ST_RD1;
      dvt_pkg::ST_RD1: state_nxt = dvt_pkg::ST_RD2;
      dvt_pkg::ST_RD2: state_nxt = dvt_pkg::ST_DONE;
      dvt_pkg::ST_DONE: begin
        if (out_free) state_nxt = dvt_pkg::ST_IDLE;
      end
      default: state_nxt = dvt_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    mem_ra0  = '0;
    mem_ra1  = '0;
    unique case (state_r)
      dvt_pkg::ST_INIT, dvt_pkg::ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = INF;
      end
      dvt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      dvt_pkg::ST_WRITE: begin
        mem_we = lt_nodes(row_r) && lt_nodes(col_r);
        mem_wa = {to_idx(row_r), to_idx(col_r)};
        mem_wd = value_r;
      end
      dvt_pkg::ST_LINK: begin
        mem_ra0 = {sender_idx, self_idx};
      end
      dvt_pkg::ST_RELAX_A: begin
        // store the sender's column, fetch the own entry of the same row
        mem_we  = 1'b1;
        mem_wa  = {idx_i_r, sender_idx};
        mem_wd  = vec_i;
        mem_ra0 = {idx_i_r, self_idx};
      end
      dvt_pkg::ST_RELAX_B: begin
        mem_we = relax_better;
        mem_wa = {idx_i_r, self_idx};
        mem_wd = relax_sum[CW-1:0];
      end
      dvt_pkg::ST_SYM_A: begin
        mem_ra0 = {idx_j_r, idx_i_r};
        mem_ra1 = {idx_i_r, idx_j_r};
      end
      dvt_pkg::ST_SYM_B: begin
        // writes hit column i off the diagonal, so the next pair can be read at once
        mem_we  = sym_swap;
        mem_wa  = {idx_j_r, idx_i_r};
        mem_wd  = rd1_r;
        mem_ra0 = {idx_j_inc, idx_i_r};
        mem_ra1 = {idx_i_r, idx_j_inc};
      end
      dvt_pkg::ST_SYM_DIAG: begin
        mem_we = diag_r;
        mem_wa = {idx_i_r, idx_i_r};
        mem_wd = '0;
      end
      dvt_pkg::ST_RD0: begin
        mem_ra0 = {to_idx(2'd0), self_idx};
        mem_ra1 = {to_idx(2'd1), self_idx};
      end
      dvt_pkg::ST_RD1: begin
        mem_ra0 = {to_idx(2'd2), self_idx};
        mem_ra1 = {to_idx(2'd3), self_idx};
      end
      dvt_pkg::ST_RD2, dvt_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd0_r <= mem[mem_ra0];
    rd1_r <= mem[mem_ra1];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dvt_pkg::ST_INIT;
      self_id_r   <= '0;
      nbr_mask_r  <= '0;
      idx_i_r     <= '0;
      idx_j_r     <= '0;
      clr_cnt_r   <= '0;
      diag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == dvt_pkg::CFG_SELF_ID) begin
          self_id_r <= cfg_wdata[dvt_pkg::ID_W-1:0];
        end else if (cfg_index == dvt_pkg::CFG_NEIGHBOR_MASK) begin
          nbr_mask_r <= cfg_wdata;
        end
      end
      // raise a fresh result, else drop the one just taken
      if (state_r == dvt_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        dvt_pkg::ST_INIT, dvt_pkg::ST_FILL: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
        end
        dvt_pkg::ST_IDLE: begin
          clr_cnt_r <= '0;
          idx_i_r   <= '0;
          idx_j_r   <= '0;
        end
        dvt_pkg::ST_RELAX_B: begin
          idx_i_r <= (idx_i_r == LAST_IDX) ? '0 : idx_i_r + 1'b1;
          idx_j_r <= '0;
        end
        dvt_pkg::ST_SYM_A: begin
          diag_r  <= 1'b0;
          idx_j_r <= '0;
        end
        dvt_pkg::ST_SYM_B: begin
          if (sym_swap) diag_r <= 1'b1;
          idx_j_r <= (idx_j_r == LAST_IDX) ? '0 : idx_j_inc;
        end
        dvt_pkg::ST_SYM_DIAG: begin
          idx_i_r <= (idx_i_r == LAST_IDX) ? '0 : idx_i_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      dvt_pkg::ST_IDLE: begin
        if (in_acc) begin
          sender_r <= in_sender_id;
          row_r    <= in_entry_row;
          col_r    <= in_entry_col;
          value_r  <= in_entry_value;
          min_r[0] <= in_min_cost_0;
          min_r[1] <= in_min_cost_1;
          min_r[2] <= in_min_cost_2;
          min_r[3] <= in_min_cost_3;
          upd_r    <= 1'b0;
        end
      end
      dvt_pkg::ST_RELAX_A: begin
        // link cost arrives from the read issued in the link state
        if (idx_i_r == '0) link_r <= rd0_r;
      end
      dvt_pkg::ST_RELAX_B: begin
        if (relax_better) begin
          upd_r <= 1'b1;
          if (idx_i_r == sender_idx) link_r <= relax_sum[CW-1:0];
        end
      end
      dvt_pkg::ST_RD1: begin
        own_r[0] <= self_ok ? rd0_r : '0;
        own_r[1] <= self_ok ? rd1_r : '0;
      end
      dvt_pkg::ST_RD2: begin
        own_r[2] <= (self_ok && (NODES > 2)) ? rd0_r : '0;
        own_r[3] <= (self_ok && (NODES > 3)) ? rd1_r : '0;
      end
      dvt_pkg::ST_DONE: begin
        if (out_free) begin
          out_updated_r <= upd_r;
          out_cost_r    <= own_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_updated    = out_updated_r;
  assign out_own_cost_0 = out_cost_r[0];
  assign out_own_cost_1 = out_cost_r[1];
  assign out_own_cost_2 = out_cost_r[2];
  assign out_own_cost_3 = out_cost_r[3];

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dvt_pkg::ST_IDLE || state_r == dvt_pkg::ST_DONE) |-> !mem_we)
    else $error("table written outside a request");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == dvt_pkg::ST_DONE)
    else $error("result raised outside the done state");

  a_sym_off_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dvt_pkg::ST_SYM_B && mem_we) |-> idx_j_r != idx_i_r)
    else $error("symmetric fill wrote a diagonal entry");

  a_relax_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dvt_pkg::ST_RELAX_A && relax_en) |-> mem_wa != mem_ra0)
    else $error("column store and own-entry read on the same entry");

endmodule
